// ===== rtl/core/mspd_pkg.sv =====
// Shared types and constants for the MSP v1 response deframer.
// No dependencies.
package mspd_pkg;

  localparam logic [7:0]  HDR_DOLLAR = 8'h24;
  localparam logic [7:0]  HDR_M      = 8'h4D;
  localparam logic [7:0]  HDR_GT     = 8'h3E;

  localparam logic        OP_BYTE = 1'b0;
  localparam logic        OP_TICK = 1'b1;

  localparam logic [1:0]  KIND_BYTE    = 2'd0;
  localparam logic [1:0]  KIND_GOOD    = 2'd1;
  localparam logic [1:0]  KIND_BADSUM  = 2'd2;
  localparam logic [1:0]  KIND_TIMEOUT = 2'd3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] GAP_MAX       = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_M    = 3'd1,
    PH_GT   = 3'd2,
    PH_SIZE = 3'd3,
    PH_CMD  = 3'd4,
    PH_DATA = 3'd5,
    PH_SUM  = 3'd6
  } phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] command;
    logic [7:0] payload_size;
  } out_item_t;

  typedef struct packed {
    logic      vld;
    out_item_t item;
  } step_res_t;

endpackage

// ===== rtl/core/msp_v1_response_deframer.sv =====
// Top level of the MSP v1 response deframer: input register, step core, result register.
// Depends on mspd_pkg and mspd_core.
//
//  channel | direction | handshake          | beat
//  --------+-----------+--------------------+------------------------------
//  in      | input     | in_valid / in_stall| op, rx_byte
//  out     | output    | out_valid/out_stall| kind, data, command, size
//  cfg     | input     | cfg_we             | byte timeout in ticks
//
// One beat per cycle while no result is held by out_stall; a result leaves
// through the input register, then the result register.
// Reset is synchronous on rst_n; it clears the frame state and sets the timeout to 1000.
// in_stall rises only while a result is held by out_stall with a beat waiting.
module msp_v1_response_deframer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mspd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output mspd_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);
  import mspd_pkg::*;

  logic        in_valid_r;
  in_item_t    in_item_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic [15:0] timeout_r;
  logic        advance;
  logic        step_en;
  step_res_t   res;

  assign advance  = !out_valid_r || !out_stall;
  assign step_en  = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  mspd_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (step_en),
    .item          (in_item_r),
    .timeout_ticks (timeout_r),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step_en && res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  a_timeout_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.kind == KIND_TIMEOUT) |-> (out_item_r.data == 8'd0))
    else $error("timeout result carries nonzero data");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !in_valid_r))
    else $error("valid flags not cleared by reset");

endmodule

// ===== rtl/core/mspd_core.sv =====
// Frame state machine and per-beat step logic of the deframer.
// Depends on mspd_pkg.
module mspd_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  mspd_pkg::in_item_t item,
  input  logic [15:0]        timeout_ticks,
  output mspd_pkg::step_res_t res
);
  import mspd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  remaining_r, remaining_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  size_r, size_nxt;
  logic [15:0] gap_r, gap_nxt;
  logic [15:0] gap_inc;
  logic        in_frame;
  logic        is_tick;
  logic        tmo_hit;
  logic [7:0]  b;

  assign b        = item.rx_byte;
  assign is_tick  = (item.op == OP_TICK);
  assign in_frame = (phase_r == PH_SIZE) || (phase_r == PH_CMD) ||
                    (phase_r == PH_DATA) || (phase_r == PH_SUM);
  assign gap_inc  = (gap_r == GAP_MAX) ? gap_r : gap_r + 16'd1;
  assign tmo_hit  = is_tick && in_frame && (gap_inc > timeout_ticks);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (is_tick) begin
      if (tmo_hit) begin
        phase_nxt = PH_HUNT;
      end
    end else begin
      unique case (phase_r)
        PH_HUNT: if (b == HDR_DOLLAR) phase_nxt = PH_M;
        PH_M: begin
          if (b == HDR_M)           phase_nxt = PH_GT;
          else if (b == HDR_DOLLAR) phase_nxt = PH_M;
          else                      phase_nxt = PH_HUNT;
        end
        PH_GT: begin
          if (b == HDR_GT)          phase_nxt = PH_SIZE;
          else if (b == HDR_DOLLAR) phase_nxt = PH_M;
          else                      phase_nxt = PH_HUNT;
        end
        PH_SIZE: phase_nxt = PH_CMD;
        PH_CMD:  phase_nxt = (remaining_r == 8'd0) ? PH_SUM : PH_DATA;
        PH_DATA: if (remaining_r == 8'd1) phase_nxt = PH_SUM;
        PH_SUM:  phase_nxt = PH_HUNT;
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    remaining_nxt = remaining_r;
    xor_nxt       = xor_r;
    cmd_nxt       = cmd_r;
    size_nxt      = size_r;
    gap_nxt       = gap_r;
    res.vld       = 1'b0;
    res.item.kind = KIND_BYTE;
    res.item.data = 8'd0;
    // header fields reflect the frame as it stands when the result forms
    res.item.command      = cmd_r;
    res.item.payload_size = size_r;
    if (is_tick) begin
      if (tmo_hit) begin
        gap_nxt       = 16'd0;
        res.vld       = 1'b1;
        res.item.kind = KIND_TIMEOUT;
      end else if (in_frame) begin
        gap_nxt = gap_inc;
      end
    end else begin
      gap_nxt = 16'd0;
      unique case (phase_r)
        PH_GT: begin
          if (b == HDR_GT) begin
            cmd_nxt       = 8'd0;
            size_nxt      = 8'd0;
            xor_nxt       = 8'd0;
            remaining_nxt = 8'd0;
          end
        end
        PH_SIZE: begin
          size_nxt      = b;
          remaining_nxt = b;
          xor_nxt       = b;
        end
        PH_CMD: begin
          cmd_nxt = b;
          xor_nxt = xor_r ^ b;
        end
        PH_DATA: begin
          xor_nxt       = xor_r ^ b;
          remaining_nxt = remaining_r - 8'd1;
          res.vld       = 1'b1;
          res.item.kind = KIND_BYTE;
          res.item.data = b;
        end
        PH_SUM: begin
          res.vld       = 1'b1;
          res.item.kind = (b == xor_r) ? KIND_GOOD : KIND_BADSUM;
          res.item.data = b;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      remaining_r <= 8'd0;
      xor_r       <= 8'd0;
      cmd_r       <= 8'd0;
      size_r      <= 8'd0;
      gap_r       <= 16'd0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      xor_r       <= xor_nxt;
      cmd_r       <= cmd_nxt;
      size_r      <= size_nxt;
      gap_r       <= gap_nxt;
    end
  end

endmodule
